@@ rtl/tpsd_pkg.sv @@
// Shared definitions for the TGA pixel stream decoder.
// Holds register indexes, supported depths and the result record type.
// No dependencies.
package tpsd_pkg;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BPP      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 8'd4;

    // Pixel depths.
    localparam logic [5:0] BPP_16    = 6'd16;
    localparam logic [5:0] BPP_24    = 6'd24;
    localparam logic [5:0] BPP_32    = 6'd32;
    localparam logic [5:0] BPP_RESET = BPP_24;

    // One decoded result.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       last_pixel;
        logic       format_error;
    } result_t;

endpackage

@@ rtl/tga_pixel_stream_decoder_core.sv @@
// TGA pixel stream decoder core: one data byte per cycle while the byte channel is not
// stalled, 0 or 1 result per byte. A result is registered when its last byte is taken.
// A two-entry output (register plus skid) absorbs pixel channel stalls.
// After a register write the byte channel stalls while the pixel count
// is reloaded from the 16x16 width-times-height product.
// Reset (rst_n, asynchronous, active low): raw 24-bit 1x1 image, header phase, no result.
module tga_pixel_stream_decoder_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Byte channel
    input  logic                              byte_valid,
    output logic                              byte_stall,
    input  logic [7:0]                        data_byte,
    // Pixel channel
    output logic                              pixel_valid,
    input  logic                              pixel_stall,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic [7:0]                        alpha,
    output logic [7:0]                        repeat_count,
    output logic                              last_pixel,
    output logic                              format_error,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tpsd_pkg::*;

    typedef enum logic [1:0] {
        PHASE_HEADER,
        PHASE_LITERAL,
        PHASE_RUN
    } phase_t;

    // Configuration registers.
    logic        rle_mode_reg, rle_mode_next;
    logic [5:0]  bpp_reg, bpp_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic [1:0]  bip_reg, bip_next;
    logic [23:0] held_reg, held_next;
    logic [31:0] img_left_reg, img_left_next;
    logic [31:0] total_reg;
    logic        reload_reg, reload_next;

    // Output register and skid entry.
    result_t     out_reg, out_next;
    result_t     skid_reg, skid_next;
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;

    logic        byte_acc;
    logic        cfg_wr;
    logic        supported;
    logic [1:0]  last_bip;
    logic [31:0] total_prod;
    logic [31:0] total_comb;
    logic        produce;
    result_t     res;
    logic [7:0]  count;
    logic [7:0]  count_clip;
    logic [31:0] img_left_dec;
    logic        out_take;

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid & cfg_ready;
    assign byte_stall = skid_valid_reg | reload_reg;
    assign byte_acc   = byte_valid & ~byte_stall;
    assign out_take   = out_valid_reg & ~pixel_stall;

    // Format check and bytes per pixel.
    assign supported = (bpp_reg == BPP_24) || (bpp_reg == BPP_32) ||
                       (!rle_mode_reg && (bpp_reg == BPP_16));

    always_comb
    begin
        case (bpp_reg)
            BPP_16:  last_bip = 2'd1;
            BPP_24:  last_bip = 2'd2;
            default: last_bip = 2'd3;
        endcase
    end

    // Image size; an empty image counts as one pixel.
    assign total_prod = {16'd0, width_reg} * {16'd0, height_reg};
    assign total_comb = (total_prod == 32'd0) ? 32'd1 : total_prod;

    // Per-byte decode and state update.
    always_comb
    begin
        rle_mode_next = rle_mode_reg;
        bpp_next      = bpp_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        phase_next    = phase_reg;
        pkt_left_next = pkt_left_reg;
        bip_next      = bip_reg;
        held_next     = held_reg;
        img_left_next = img_left_reg;
        reload_next   = reload_reg;
        produce       = 1'b0;
        res           = '0;
        count         = 8'd1;
        count_clip    = 8'd1;
        img_left_dec  = img_left_reg;

        if (byte_acc) begin
            if (!supported) begin
                produce          = 1'b1;
                res.format_error = 1'b1;
            end else if (rle_mode_reg && (phase_reg != PHASE_LITERAL) &&
                         (phase_reg != PHASE_RUN)) begin
                // Packet header: both kinds carry the low seven bits plus one.
                phase_next    = data_byte[7] ? PHASE_RUN : PHASE_LITERAL;
                pkt_left_next = {1'b0, data_byte[6:0]} + 8'd1;
            end else if (bip_reg != last_bip) begin
                // Hold an early byte of the pixel.
                case (bip_reg)
                    2'd0:    held_next[7:0]   = data_byte;
                    2'd1:    held_next[15:8]  = data_byte;
                    2'd2:    held_next[23:16] = data_byte;
                    default: held_next        = held_reg;
                endcase
                bip_next = bip_reg + 2'd1;
            end else begin
                // Final byte: assemble the color.
                if (bpp_reg == BPP_16) begin
                    res.red   = {data_byte[6:2], 3'b000};
                    res.green = {data_byte[1:0], held_reg[7:5], 3'b000};
                    res.blue  = {held_reg[4:0], 3'b000};
                    res.alpha = 8'd0;
                end else if (bpp_reg == BPP_24) begin
                    res.red   = data_byte;
                    res.green = held_reg[15:8];
                    res.blue  = held_reg[7:0];
                    res.alpha = 8'd0;
                end else begin
                    res.red   = held_reg[23:16];
                    res.green = held_reg[15:8];
                    res.blue  = held_reg[7:0];
                    res.alpha = data_byte;
                end
                held_next = 24'd0;
                bip_next  = 2'd0;

                // Repeat count by packet kind.
                if (!rle_mode_reg) begin
                    count = 8'd1;
                end else if (phase_reg == PHASE_LITERAL) begin
                    count         = 8'd1;
                    pkt_left_next = pkt_left_reg - 8'd1;
                    if (pkt_left_reg == 8'd1) begin
                        phase_next = PHASE_HEADER;
                    end
                end else begin
                    count         = pkt_left_reg;
                    phase_next    = PHASE_HEADER;
                    pkt_left_next = 8'd0;
                end

                // Clip at the image end.
                if (img_left_reg < {24'd0, count}) begin
                    count_clip = img_left_reg[7:0];
                end else begin
                    count_clip = count;
                end
                img_left_dec      = img_left_reg - {24'd0, count_clip};
                img_left_next     = img_left_dec;
                produce           = 1'b1;
                res.repeat_count  = count_clip;
                res.last_pixel    = (img_left_dec == 32'd0);

                // Restart for the next image.
                if (img_left_dec == 32'd0) begin
                    phase_next    = PHASE_HEADER;
                    pkt_left_next = 8'd0;
                    bip_next      = 2'd0;
                    held_next     = 24'd0;
                    img_left_next = total_reg;
                end
            end
        end

        // Register writes restart the decoder; the reload flag then reloads the count.
        if (cfg_wr && (cfg_index < REG_COUNT)) begin
            case (cfg_index)
                REG_RLE_MODE: rle_mode_next = cfg_data[0];
                REG_BPP:      bpp_next      = cfg_data[5:0];
                REG_WIDTH:    width_next    = cfg_data;
                REG_HEIGHT:   height_next   = cfg_data;
                default:      rle_mode_next = rle_mode_reg;
            endcase
            phase_next    = PHASE_HEADER;
            pkt_left_next = 8'd0;
            bip_next      = 2'd0;
            held_next     = 24'd0;
            reload_next   = 1'b1;
        end else if (reload_reg) begin
            img_left_next = total_comb;
            reload_next   = 1'b0;
        end
    end

    // Output register with one skid entry.
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg) begin
            if (out_take) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || out_take) begin
            out_next       = res;
            out_valid_next = produce;
        end else if (produce) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    // Control and parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rle_mode_reg   <= 1'b0;
            bpp_reg        <= BPP_RESET;
            width_reg      <= 16'd1;
            height_reg     <= 16'd1;
            phase_reg      <= PHASE_HEADER;
            pkt_left_reg   <= 8'd0;
            bip_reg        <= 2'd0;
            held_reg       <= 24'd0;
            img_left_reg   <= 32'd1;
            total_reg      <= 32'd1;
            reload_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            rle_mode_reg   <= rle_mode_next;
            bpp_reg        <= bpp_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            phase_reg      <= phase_next;
            pkt_left_reg   <= pkt_left_next;
            bip_reg        <= bip_next;
            held_reg       <= held_next;
            img_left_reg   <= img_left_next;
            total_reg      <= total_comb;
            reload_reg     <= reload_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign pixel_valid  = out_valid_reg;
    assign red          = out_reg.red;
    assign green        = out_reg.green;
    assign blue         = out_reg.blue;
    assign alpha        = out_reg.alpha;
    assign repeat_count = out_reg.repeat_count;
    assign last_pixel   = out_reg.last_pixel;
    assign format_error = out_reg.format_error;

endmodule
